// ===== rtl/core/saturating_recurrent_gemv_row_assert.svh =====
// Assertion macros shared by the row unit modules.
// Depends on nothing; expects a clock i_clk and a reset i_rst_n in scope.
`ifndef SATURATING_RECURRENT_GEMV_ROW_ASSERT_SVH
`define SATURATING_RECURRENT_GEMV_ROW_ASSERT_SVH

// Check a property only while out of reset.
`define SRGR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property at every clock edge, reset included.
`define SRGR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/core/srgr_pkg.sv =====
// Shared types and constants of the recurrent row unit.
// Used by the controller, the datapath and the top level.
package srgr_pkg;

    localparam int ACT_W    = 16;
    localparam int WGT_W    = 8;
    localparam int BIAS_W   = 32;
    localparam int MULT_W   = 8;
    localparam int PROD1_W  = ACT_W + WGT_W;
    localparam int PROD2_W  = 32;
    localparam int ACC_W    = 64;
    localparam int RES_W    = 32;
    localparam int CNT_W    = 32;
    localparam int CHUNK_W  = 16;
    localparam int IN_DW    = 64;
    localparam int OUT_DW   = 64;

    localparam logic [CHUNK_W-1:0] CHUNK_RESET = 16'd1024;
    localparam logic [ACC_W-1:0]   SAT_MAX = 64'h0000_0000_7FFF_FFFF;
    localparam logic [ACC_W-1:0]   SAT_MIN = 64'hFFFF_FFFF_8000_0000;
    localparam logic [CNT_W-1:0]   CNT_FULL = '1;

    typedef struct packed {
        logic load;   // input transfer: latch element, open row if needed
        logic mul;    // activation times weight
        logic scale;  // product times row multiplier
        logic acc;    // add into accumulator, advance column count
        logic sat;    // saturate at chunk boundary or row end
        logic post;   // update clip flag and counter, close row
        logic emit;   // load output register
    } t_cmd;

    typedef struct packed {
        logic row_last;  // element in flight ends its row
        logic out_free;  // output register can take a result this cycle
    } t_status;

endpackage

// ===== rtl/core/srgr_ctrl.sv =====
// Sequencer of the recurrent row unit: walks one element through the datapath.
// Depends on srgr_pkg and the assertion macro header.
`include "saturating_recurrent_gemv_row_assert.svh"

module srgr_ctrl
    import srgr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SCALE,
        S_ACC,
        S_SAT,
        S_POST
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_post_go;

    assign w_post_go = (r_state == S_POST) && (!i_status.row_last || i_status.out_free);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cmd.load  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.mul   = (r_state == S_MUL);
    assign o_cmd.scale = (r_state == S_SCALE);
    assign o_cmd.acc   = (r_state == S_ACC);
    assign o_cmd.sat   = (r_state == S_SAT);
    assign o_cmd.post  = w_post_go;
    assign o_cmd.emit  = w_post_go && i_status.row_last;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_MUL;
            S_MUL:   n_state = S_SCALE;
            S_SCALE: n_state = S_ACC;
            S_ACC:   n_state = S_SAT;
            S_SAT:   n_state = S_POST;
            S_POST:  if (w_post_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `SRGR_ASSERT(a_load_then_mul, o_cmd.load |=> o_cmd.mul, "multiply did not follow a transfer")
    `SRGR_ASSERT(a_emit_needs_room, o_cmd.emit |-> i_status.out_free, "result loaded over a pending one")
    `SRGR_ASSERT(a_one_step, $onehot0({o_cmd.load, o_cmd.mul, o_cmd.scale, o_cmd.acc, o_cmd.sat, o_cmd.post}), "two datapath steps at once")

endmodule

// ===== rtl/core/srgr_datapath.sv =====
// Datapath of the recurrent row unit: operand latches, two multiply stages,
// 64-bit accumulator with saturation, clip bookkeeping and output register.
// Depends on srgr_pkg and the assertion macro header.
`include "saturating_recurrent_gemv_row_assert.svh"

module srgr_datapath
    import srgr_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    input  logic                i_cfg_we,
    input  logic [CHUNK_W-1:0]  i_cfg_wdata,
    input  logic [IN_DW-1:0]    i_in_data,
    input  logic                i_in_last,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [OUT_DW-1:0]   o_out_data,
    output logic                o_out_user
);

    localparam int CMP_W = (COUNT_WIDTH > CHUNK_W) ? COUNT_WIDTH : CHUNK_W;

    logic [CHUNK_W-1:0]         r_chunk;
    logic signed [ACT_W-1:0]    r_act;
    logic signed [WGT_W-1:0]    r_wgt;
    logic                       r_last;
    logic                       r_row_open;
    logic [MULT_W-1:0]          r_scale;
    logic signed [PROD1_W-1:0]  r_p1;
    logic signed [PROD2_W-1:0]  r_p2;
    logic [ACC_W-1:0]           r_acc;
    logic [COUNT_WIDTH-1:0]     r_col;
    logic                       r_bound;
    logic                       r_clip_evt;
    logic                       r_row_clipped;
    logic [CNT_W-1:0]           r_clip_cnt;
    logic                       r_out_valid;
    logic [OUT_DW-1:0]          r_out_data;
    logic                       r_out_user;

    logic signed [PROD2_W:0]    w_p2_full;
    logic [COUNT_WIDTH-1:0]     n_col;
    logic                       w_ovf;
    logic [CNT_W-1:0]           n_clip_cnt;
    logic                       n_row_clipped;

    assign w_p2_full = r_p1 * $signed({1'b0, r_scale});
    assign n_col     = r_col + 1'b1;
    assign w_ovf     = r_acc[ACC_W-1:RES_W-1] != {(ACC_W-RES_W+1){r_acc[ACC_W-1]}};

    assign n_clip_cnt    = (r_clip_evt && r_clip_cnt != CNT_FULL) ? r_clip_cnt + 1'b1
                                                                  : r_clip_cnt;
    assign n_row_clipped = r_row_clipped | r_clip_evt;

    assign o_status.row_last = r_last;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_user  = r_out_user;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk       <= CHUNK_RESET;
            r_row_open    <= 1'b0;
            r_row_clipped <= 1'b0;
            r_clip_cnt    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_chunk <= i_cfg_wdata;
            end
            if (i_cmd.load && !r_row_open) begin
                r_row_open    <= 1'b1;
                r_row_clipped <= 1'b0;
            end
            if (i_cmd.post) begin
                r_clip_cnt    <= n_clip_cnt;
                r_row_clipped <= r_last ? 1'b0 : n_row_clipped;
                if (r_last) begin
                    r_row_open <= 1'b0;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act  <= i_in_data[ACT_W-1:0];
            r_wgt  <= i_in_data[ACT_W+WGT_W-1:ACT_W];
            r_last <= i_in_last;
            if (!r_row_open) begin
                r_acc   <= {{(ACC_W-BIAS_W){i_in_data[ACT_W+WGT_W+BIAS_W-1]}},
                            i_in_data[ACT_W+WGT_W+BIAS_W-1:ACT_W+WGT_W]};
                r_scale <= i_in_data[IN_DW-1:ACT_W+WGT_W+BIAS_W];
                r_col   <= '0;
            end
        end
        if (i_cmd.mul) begin
            r_p1 <= r_act * r_wgt;
        end
        if (i_cmd.scale) begin
            // |act * weight * scale| stays below 2^30
            r_p2 <= w_p2_full[PROD2_W-1:0];
        end
        if (i_cmd.acc) begin
            r_acc   <= r_acc + {{(ACC_W-PROD2_W){r_p2[PROD2_W-1]}}, r_p2};
            r_col   <= n_col;
            r_bound <= (r_chunk != '0) && (CMP_W'(n_col) == CMP_W'(r_chunk));
        end
        if (i_cmd.sat) begin
            r_clip_evt <= (r_bound || r_last) && w_ovf;
            if ((r_bound || r_last) && w_ovf) begin
                r_acc <= r_acc[ACC_W-1] ? SAT_MIN : SAT_MAX;
            end
            if (r_bound) begin
                r_col <= '0;
            end
        end
        if (i_cmd.emit) begin
            r_out_data <= {n_clip_cnt, r_acc[RES_W-1:0]};
            r_out_user <= n_row_clipped;
        end
    end

    `SRGR_ASSERT(a_sat_in_range, ($past(i_cmd.sat) && $past(r_bound || r_last)) |-> !w_ovf, "accumulator out of range after saturation")
    `SRGR_ASSERT_ALWAYS(a_cnt_monotonic, (i_rst_n && $past(i_rst_n)) |-> (r_clip_cnt >= $past(r_clip_cnt)), "clip counter went down")
    `SRGR_ASSERT(a_emit_in_row, i_cmd.emit |-> r_row_open, "result emitted with no open row")

endmodule

// ===== rtl/core/saturating_recurrent_gemv_row.sv =====
// Top level of the saturating recurrent row unit.
// Depends on srgr_pkg, srgr_ctrl and srgr_datapath.

// Computes one output of a recurrent layer from a stream of row elements.
// Each transfer on the slave side carries one element (activation, weight)
// together with the row bias and multiplier; bias and multiplier are taken
// only on the first element of a row, and tlast closes the row. The 64-bit
// sum starts at the bias and adds activation * weight * multiplier. After
// every chunk_length elements (written through i_cfg_we / i_cfg_wdata, reset
// value 1024, zero disables intermediate saturation) and at the row end the
// sum is clamped to signed 32 bits; each clamp that changes the value sets
// the row's clipped flag and bumps a running clip total that sticks at
// all ones. One result leaves on the master side per row.
// Each element passes transfer, multiply, scale, accumulate, saturate, post
// before another is taken; this is set by the two registered multiply steps
// feeding the 64-bit accumulator and its separate saturation step. At a row
// end the post step waits while the output register still holds an untaken
// result; a new element can be accepted while a finished result waits.
module saturating_recurrent_gemv_row
    import srgr_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration: chunk_length
    input  logic               i_cfg_we,
    input  logic [CHUNK_W-1:0] i_cfg_wdata,
    // Element stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // [15:0] activation, [23:16] weight, [55:24] bias, [63:56] multiplier
    input  logic [IN_DW-1:0]   s_axis_tdata,
    input  logic               s_axis_tlast,   // last_in_row
    // Result stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [31:0] row_result, [63:32] saturation_total
    output logic [OUT_DW-1:0]  m_axis_tdata,
    // [0] clipped
    output logic               m_axis_tuser
);

    t_cmd    w_cmd;
    t_status w_status;

    // Sequence each element through the datapath
    srgr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Arithmetic, row state and output register
    srgr_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (s_axis_tdata),
        .i_in_last   (s_axis_tlast),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser)
    );

endmodule

// ===== tb/tb_saturating_recurrent_gemv_row.sv =====
// Self-checking testbench for the saturating recurrent row unit.
// Depends on srgr_pkg and the saturating_recurrent_gemv_row RTL; needs no other file.
// Directed rows, then random rows over several chunk lengths, checked against a row predictor.
module tb_saturating_recurrent_gemv_row;
    import srgr_pkg::*;

    localparam int COUNT_WIDTH = 16;
    localparam int DRAIN_CYCLES = 20;

    // One row element as it travels on the slave side.
    typedef struct packed {
        logic                row_last;
        logic [MULT_W-1:0]   mult;
        logic [BIAS_W-1:0]   bias;
        logic [WGT_W-1:0]    wgt;
        logic [ACT_W-1:0]    act;
    } t_elem;

    // One finished row as it should leave on the master side.
    typedef struct packed {
        logic [RES_W-1:0] value;
        logic             clip;
        logic [CNT_W-1:0] total;
    } t_row_out;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [CHUNK_W-1:0] i_cfg_wdata = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    // [15:0] activation, [23:16] weight, [55:24] bias, [63:56] multiplier
    logic [IN_DW-1:0]   s_axis_tdata = '0;
    logic               s_axis_tlast = 1'b0;   // last_in_row
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    // [31:0] row_result, [63:32] saturation_total
    logic [OUT_DW-1:0]  m_axis_tdata;
    // [0] clipped
    logic               m_axis_tuser;

    saturating_recurrent_gemv_row #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Elements waiting to be sent; the front one is the one on the bus.
    t_elem    element_queue[$];
    // Finished rows the block still owes us, oldest first.
    t_row_out row_result_queue[$];

    // Predictor copy of the row state and the chunk register.
    logic [ACC_W-1:0]       row_sum;
    logic [COUNT_WIDTH-1:0] col_count;
    logic [MULT_W-1:0]      row_scale;
    logic                   row_clip;
    logic [CNT_W-1:0]       clip_total;
    logic                   row_open;
    logic [CHUNK_W-1:0]     chunk_len;

    bit failed = 1'b0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned send_gap = 0;
    int unsigned recv_gap = 0;

    // Clamp the running sum to signed 32 bits; count each clamp that changes it.
    task automatic clamp_sum();
        logic hit;
        hit = 1'b0;
        if (!row_sum[ACC_W-1] && row_sum > SAT_MAX) begin
            row_sum = SAT_MAX;
            hit = 1'b1;
        end else if (row_sum[ACC_W-1] && row_sum < SAT_MIN) begin
            row_sum = SAT_MIN;
            hit = 1'b1;
        end
        if (hit) begin
            row_clip = 1'b1;
            if (clip_total != CNT_FULL)
                clip_total = clip_total + 1'b1;
        end
    endtask

    // Fold one accepted element into the row; queue the row output at its end.
    task automatic accumulate_element(input t_elem e);
        logic signed [ACC_W-1:0] a64;
        logic signed [ACC_W-1:0] w64;
        logic signed [ACC_W-1:0] m64;
        t_row_out                r;
        if (!row_open) begin
            // First element of a row: load the bias, latch the multiplier.
            row_sum   = {{(ACC_W-BIAS_W){e.bias[BIAS_W-1]}}, e.bias};
            row_scale = e.mult;
            row_clip  = 1'b0;
            col_count = '0;
            row_open  = 1'b1;
        end
        a64 = $signed(e.act);
        w64 = $signed(e.wgt);
        m64 = {{(ACC_W-MULT_W){1'b0}}, row_scale};
        row_sum = row_sum + a64 * w64 * m64;
        col_count = col_count + 1'b1;
        // Zero chunk length never meets a boundary.
        if (chunk_len != '0 && col_count == chunk_len) begin
            clamp_sum();
            col_count = '0;
        end
        if (e.row_last) begin
            clamp_sum();
            r.value = row_sum[RES_W-1:0];
            r.clip  = row_clip;
            r.total = clip_total;
            row_result_queue.push_back(r);
            row_sum   = '0;
            col_count = '0;
            row_scale = '0;
            row_clip  = 1'b0;
            row_open  = 1'b0;
        end
    endtask

    // Pick a field value, biased toward the extremes of a signed field.
    function automatic logic [31:0] pick_value(input int unsigned width);
        logic [31:0] mask;
        logic [31:0] msb;
        mask = (width == 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 1);
        msb  = 32'd1 << (width - 1);
        case ($urandom_range(9))
            0: return msb;            // most negative
            1: return msb - 1;        // most positive
            2: return '0;
            3: return mask;           // minus one / all ones
            default: return $urandom & mask;
        endcase
    endfunction

    function automatic t_elem make_elem(input logic [15:0] act, input logic [7:0] wgt,
                                        input logic [31:0] bias, input logic [7:0] mult,
                                        input logic row_last);
        t_elem e;
        e.act = act;
        e.wgt = wgt;
        e.bias = bias;
        e.mult = mult;
        e.row_last = row_last;
        return e;
    endfunction

    function automatic t_elem random_elem(input logic row_last);
        return make_elem(ACT_W'(pick_value(ACT_W)), WGT_W'(pick_value(WGT_W)),
                         BIAS_W'(pick_value(BIAS_W)), MULT_W'(pick_value(MULT_W)),
                         row_last);
    endfunction

    // Driver: present the front element, hold it until the transfer, then
    // predict it. Idle in random bursts between elements.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                accumulate_element(element_queue.pop_front());
            if (s_axis_tvalid && !s_axis_tready) begin
                // hold the element until the block takes it
            end else if (send_gap != 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (element_queue.size() != 0 && $urandom_range(99) < send_idle_pct) begin
                // open a burst of idle cycles whose length is drawn at random
                send_gap = $urandom_range(15);
                s_axis_tvalid <= 1'b0;
            end else if (element_queue.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {element_queue[0].mult, element_queue[0].bias,
                                  element_queue[0].wgt, element_queue[0].act};
                s_axis_tlast  <= element_queue[0].row_last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall in bursts whose length is drawn at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (recv_gap != 0) begin
            recv_gap--;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(99) < recv_idle_pct) begin
            recv_gap = $urandom_range(15);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: compare every result transfer with the oldest expected row.
    always @(posedge i_clk) begin
        t_row_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (row_result_queue.size() == 0) begin
                $display("%0t: unexpected result: actual row_result %0d clipped %0b total %0d",
                         $time, $signed(m_axis_tdata[31:0]), m_axis_tuser,
                         m_axis_tdata[63:32]);
                failed = 1'b1;
            end else begin
                want = row_result_queue.pop_front();
                if (m_axis_tdata[31:0] !== want.value) begin
                    $display("%0t: row_result mismatch: expected %0d, actual %0d", $time,
                             $signed(want.value), $signed(m_axis_tdata[31:0]));
                    failed = 1'b1;
                end
                if (m_axis_tuser !== want.clip) begin
                    $display("%0t: clipped mismatch: expected %0b, actual %0b", $time,
                             want.clip, m_axis_tuser);
                    failed = 1'b1;
                end
                if (m_axis_tdata[63:32] !== want.total) begin
                    $display("%0t: saturation_total mismatch: expected %0d, actual %0d",
                             $time, want.total, m_axis_tdata[63:32]);
                    failed = 1'b1;
                end
            end
        end
    end

    // Wait until every element is sent and every row is out, then let the
    // pipeline drain so no element without a result is still in flight.
    task automatic wait_idle();
        while (element_queue.size() != 0 || row_result_queue.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write the chunk length while idle, then stream random rows.
    task automatic run_phase(input logic [CHUNK_W-1:0] chunk, input int n_items,
                             input int unsigned idle_pct);
        int sent;
        int len;
        int pick;
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= chunk;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        chunk_len = chunk;
        send_idle_pct = idle_pct;
        recv_idle_pct = idle_pct;
        sent = 0;
        // Mostly short rows, some long enough to cross several chunk boundaries.
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 70)
                len = $urandom_range(6, 1);
            else if (pick < 95)
                len = $urandom_range(40, 7);
            else
                len = $urandom_range(120, 41);
            for (int i = 0; i < len; i++)
                element_queue.push_back(random_elem(i == len - 1));
            sent += len;
        end
        wait_idle();
    endtask

    initial begin
        row_sum    = '0;
        col_count  = '0;
        row_scale  = '0;
        row_clip   = 1'b0;
        clip_total = '0;
        row_open   = 1'b0;
        chunk_len  = CHUNK_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows at the reset chunk length, with moderate idling.
        send_idle_pct = 20;
        recv_idle_pct = 20;
        // single-element rows that clip high and low
        element_queue.push_back(make_elem(16'h7FFF, 8'h7F, 32'h7FFF_FFFF, 8'hFF, 1'b1));
        element_queue.push_back(make_elem(16'h8000, 8'h7F, 32'h8000_0000, 8'hFF, 1'b1));
        // largest positive product, no clip
        element_queue.push_back(make_elem(16'h8000, 8'h80, 32'h0000_0000, 8'hFF, 1'b1));
        // zero multiplier leaves only the bias
        element_queue.push_back(make_elem(16'h7FFF, 8'h7F, 32'h0000_0005, 8'h00, 1'b1));
        // three big products on top of the largest bias; later bias/mult ignored
        element_queue.push_back(make_elem(16'h7FFF, 8'h7F, 32'h7FFF_FFFF, 8'hFF, 1'b0));
        element_queue.push_back(make_elem(16'h7FFF, 8'h7F, 32'h8000_0000, 8'h00, 1'b0));
        element_queue.push_back(make_elem(16'h7FFF, 8'h7F, 32'h0000_0000, 8'h01, 1'b1));
        // sum leaves the 32-bit range mid-row and comes back: only the row end clamps
        element_queue.push_back(make_elem(16'h7FFF, 8'h7F, 32'h7FFF_FFFF, 8'hFF, 1'b0));
        element_queue.push_back(make_elem(16'h8000, 8'h7F, 32'h1234_5678, 8'h10, 1'b0));
        element_queue.push_back(make_elem(16'h8000, 8'h7F, 32'hFFFF_FFFF, 8'hAA, 1'b1));
        // deep negative row
        element_queue.push_back(make_elem(16'h7FFF, 8'h80, 32'h8000_0000, 8'hFF, 1'b0));
        element_queue.push_back(make_elem(16'h7FFF, 8'h80, 32'h0000_0001, 8'h55, 1'b1));
        // all-zero and all-ones patterns
        element_queue.push_back(make_elem(16'h0000, 8'h00, 32'h0000_0000, 8'h00, 1'b1));
        element_queue.push_back(make_elem(16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 1'b1));
        wait_idle();

        // Chunk length of one puts a boundary on every element, row ends included.
        run_phase(16'd1, 100, 15);
        run_phase(16'd2, 100, 0);
        run_phase(16'd3, 100, 30);
        run_phase(16'hFFFF, 100, 10);
        // Zero chunk length: only the row end clamps.
        run_phase(16'd0, 100, 25);
        run_phase(16'($urandom_range(40, 4)), 100, 15);
        run_phase(16'($urandom), 100, 20);
        // Last stretch runs without any idling on either side.
        run_phase(16'($urandom_range(8, 1)), 100, 0);

        if (failed)
            $display("simulation failed");
        else
            $display("simulation ok");
        $finish;
    end

    // Hard stop far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
